[rtl/lfpd_pkg.sv]
// Package for the line-follow PID drive core: widths, register map, reset values and types.
// No dependencies; every RTL file imports it.
`default_nettype none

package lfpd_pkg;

    // Sample and gain format
    localparam int SAMPLE_BITS    = 12;
    localparam int GAIN_FRAC_BITS = 8;

    // Fixed field widths
    localparam int GAIN_W  = 12;
    localparam int LIM_W   = 12;
    localparam int SPEED_W = 12;
    localparam int DUTY_W  = 12;

    // Datapath widths
    localparam int ERR_W   = SAMPLE_BITS + 1;
    localparam int INT_W   = ((SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W) + 1;
    localparam int ACC_W   = INT_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + ACC_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int BASE_W  = SPEED_W + GAIN_FRAC_BITS;
    localparam int DRV_W   = ((SUM_W > BASE_W + 1) ? SUM_W : BASE_W + 1) + 1;
    localparam int WHOLE_W = DRV_W - GAIN_FRAC_BITS;

    // Stream payload widths, padded to whole bytes
    localparam int IN_RAW_W    = 2 * SAMPLE_BITS + SPEED_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = 4 * DUTY_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_FWD_PROP  = 3'd0,
        REG_FWD_INT   = 3'd1,
        REG_FWD_DERIV = 3'd2,
        REG_REV_PROP  = 3'd3,
        REG_REV_INT   = 3'd4,
        REG_REV_DERIV = 3'd5,
        REG_INT_LIMIT = 3'd6
    } reg_idx_t;

    localparam logic [GAIN_W-1:0] FWD_PROP_RST  = GAIN_W'(154);
    localparam logic [GAIN_W-1:0] FWD_INT_RST   = GAIN_W'(64);
    localparam logic [GAIN_W-1:0] FWD_DERIV_RST = GAIN_W'(38);
    localparam logic [GAIN_W-1:0] REV_PROP_RST  = GAIN_W'(307);
    localparam logic [GAIN_W-1:0] REV_INT_RST   = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] REV_DERIV_RST = GAIN_W'(77);
    localparam logic [LIM_W-1:0]  INT_LIMIT_RST = LIM_W'(1000);

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gain_set_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic [SPEED_W-1:0]     top_speed;
        logic                   go_forward;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_fwd_duty;
        logic [DUTY_W-1:0] left_rev_duty;
        logic [DUTY_W-1:0] right_fwd_duty;
        logic [DUTY_W-1:0] right_rev_duty;
    } duty_t;

    typedef struct packed {
        logic signed [INT_W-1:0] integral;
        logic signed [ERR_W-1:0] last_error;
    } pid_state_t;

endpackage

`default_nettype wire

[rtl/lfpd_law.sv]
// Control law for the line-follow PID drive: error, integral, derivative, gain products,
// duty clamping and direction routing. Purely combinational. Depends on lfpd_pkg.
`default_nettype none

module lfpd_law (
    input  wire lfpd_pkg::item_t       item,
    input  wire lfpd_pkg::gain_set_t   fwd_gains,
    input  wire lfpd_pkg::gain_set_t   rev_gains,
    input  wire [lfpd_pkg::LIM_W-1:0]  int_limit,
    input  wire lfpd_pkg::pid_state_t  state,
    output lfpd_pkg::duty_t            duty,
    output lfpd_pkg::pid_state_t       state_next
);
    import lfpd_pkg::*;

    // Drop the fraction of a positive drive and clamp it to 0..speed
    function automatic logic [DUTY_W-1:0] drive_to_duty(
        input logic signed [DRV_W-1:0] scaled,
        input logic [SPEED_W-1:0]      speed
    );
        logic [WHOLE_W-1:0] whole;
        logic [DUTY_W-1:0]  res;
        whole = scaled[DRV_W-1:GAIN_FRAC_BITS];
        if (scaled <= 0) begin
            res = '0;
        end else if (whole > WHOLE_W'(speed)) begin
            res = DUTY_W'(speed);
        end else begin
            res = whole[DUTY_W-1:0];
        end
        return res;
    endfunction

    gain_set_t               gains;
    logic signed [ERR_W-1:0]  err;
    logic signed [ACC_W-1:0]  integ;
    logic signed [ACC_W-1:0]  deriv;
    logic signed [ACC_W-1:0]  lim_pos;
    logic signed [ACC_W-1:0]  lim_neg;
    logic signed [ACC_W-1:0]  integ_sat;
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_term;
    logic signed [PROD_W-1:0] d_term;
    logic signed [SUM_W-1:0]  pid_sum;
    logic signed [DRV_W-1:0]  base;
    logic signed [DRV_W-1:0]  left_drv;
    logic signed [DRV_W-1:0]  right_drv;
    logic [DUTY_W-1:0]        left_duty;
    logic [DUTY_W-1:0]        right_duty;

    assign gains = item.go_forward ? fwd_gains : rev_gains;

    assign err   = $signed({1'b0, item.left_sample}) - $signed({1'b0, item.right_sample});
    assign integ = ACC_W'(state.integral) + ACC_W'(err);
    assign deriv = ACC_W'(err) - ACC_W'(state.last_error);

    // Gains are unsigned; a zero top bit keeps them positive in the signed product
    assign p_term = PROD_W'($signed({1'b0, gains.prop}))  * PROD_W'(err);
    assign i_term = PROD_W'($signed({1'b0, gains.integ})) * PROD_W'(integ);
    assign d_term = PROD_W'($signed({1'b0, gains.deriv})) * PROD_W'(deriv);

    assign pid_sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

    // Output above uses the unsaturated integral; only the stored copy is clamped
    assign lim_pos = ACC_W'($signed({1'b0, int_limit}));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (integ > lim_pos) begin
            integ_sat = lim_pos;
        end else if (integ < lim_neg) begin
            integ_sat = lim_neg;
        end else begin
            integ_sat = integ;
        end
    end

    assign state_next.integral   = integ_sat[INT_W-1:0];
    assign state_next.last_error = err;

    assign base      = DRV_W'($signed({1'b0, item.top_speed, {GAIN_FRAC_BITS{1'b0}}}));
    assign left_drv  = base - DRV_W'(pid_sum);
    assign right_drv = base + DRV_W'(pid_sum);

    assign left_duty  = drive_to_duty(left_drv, item.top_speed);
    assign right_duty = drive_to_duty(right_drv, item.top_speed);

    assign duty.left_fwd_duty  = item.go_forward ? left_duty  : '0;
    assign duty.left_rev_duty  = item.go_forward ? '0 : left_duty;
    assign duty.right_fwd_duty = item.go_forward ? right_duty : '0;
    assign duty.right_rev_duty = item.go_forward ? '0 : right_duty;

endmodule

`default_nettype wire

[rtl/line_follow_pid_drive_core.sv]
// Line-follow PID drive core: sample pair in, four motor PWM duties out.
// Pipeline from input transfer to result valid: input register, then result register.
// Throughput: one item per cycle unless m_tready stalls; the control law sits in one combinational step between them.
// The input stage advances whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous) empties both stages, zeroes integral and last error,
// and loads the default gain set and integral limit. Depends on lfpd_pkg and lfpd_law.
`default_nettype none

module line_follow_pid_drive_core (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    // Input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // [11:0] left_sample, [23:12] right_sample, [35:24] top_speed, rest zero
    input  wire [lfpd_pkg::IN_TDATA_W-1:0]        s_tdata,
    // [0] go_forward
    input  wire                                   s_tuser,

    // Result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // [11:0] left_fwd_duty, [23:12] left_rev_duty, [35:24] right_fwd_duty,
    // [47:36] right_rev_duty
    output logic [lfpd_pkg::OUT_TDATA_W-1:0]      m_tdata,

    // Configuration port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire [lfpd_pkg::ADDR_W-1:0]            paddr,
    input  wire [lfpd_pkg::DATA_W-1:0]            pwdata,
    output logic [lfpd_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import lfpd_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    gain_set_t          fwd_gains_reg;
    gain_set_t          rev_gains_reg;
    logic [LIM_W-1:0]   int_limit_reg;
    reg_idx_t           cfg_idx;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_gains_reg <= '{prop: FWD_PROP_RST, integ: FWD_INT_RST, deriv: FWD_DERIV_RST};
            rev_gains_reg <= '{prop: REV_PROP_RST, integ: REV_INT_RST, deriv: REV_DERIV_RST};
            int_limit_reg <= INT_LIMIT_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_FWD_PROP:  fwd_gains_reg.prop  <= pwdata[GAIN_W-1:0];
                REG_FWD_INT:   fwd_gains_reg.integ <= pwdata[GAIN_W-1:0];
                REG_FWD_DERIV: fwd_gains_reg.deriv <= pwdata[GAIN_W-1:0];
                REG_REV_PROP:  rev_gains_reg.prop  <= pwdata[GAIN_W-1:0];
                REG_REV_INT:   rev_gains_reg.integ <= pwdata[GAIN_W-1:0];
                REG_REV_DERIV: rev_gains_reg.deriv <= pwdata[GAIN_W-1:0];
                REG_INT_LIMIT: int_limit_reg       <= pwdata[LIM_W-1:0];
                default: ;  // unmapped address: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FWD_PROP:  prdata = DATA_W'(fwd_gains_reg.prop);
            REG_FWD_INT:   prdata = DATA_W'(fwd_gains_reg.integ);
            REG_FWD_DERIV: prdata = DATA_W'(fwd_gains_reg.deriv);
            REG_REV_PROP:  prdata = DATA_W'(rev_gains_reg.prop);
            REG_REV_INT:   prdata = DATA_W'(rev_gains_reg.integ);
            REG_REV_DERIV: prdata = DATA_W'(rev_gains_reg.deriv);
            REG_INT_LIMIT: prdata = DATA_W'(int_limit_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline handshake
    // in stage -> law -> result register. The in stage takes a new transfer
    // when empty or when its item moves on in the same cycle.
    // ---------------------------------------------------------------
    logic       in_valid_reg;
    item_t      in_reg;
    item_t      in_next;
    logic       m_valid_reg;
    duty_t      out_reg;
    duty_t      law_duty;
    pid_state_t state_reg;
    pid_state_t state_next;
    logic       s_xfer;
    logic       advance;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_next.left_sample  = s_tdata[SAMPLE_BITS-1:0];
    assign in_next.right_sample = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_next.top_speed    = s_tdata[2*SAMPLE_BITS+SPEED_W-1:2*SAMPLE_BITS];
    assign in_next.go_forward   = s_tuser;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg <= in_next;
        end
    end

    // ---------------------------------------------------------------
    // Control law; controller state steps once per item leaving the in stage
    // ---------------------------------------------------------------
    lfpd_law u_law (
        .item       (in_reg),
        .fwd_gains  (fwd_gains_reg),
        .rev_gains  (rev_gains_reg),
        .int_limit  (int_limit_reg),
        .state      (state_reg),
        .duty       (law_duty),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= law_duty;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_reg.right_rev_duty, out_reg.right_fwd_duty,
                                    out_reg.left_rev_duty,  out_reg.left_fwd_duty});

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // Stored integral never leaves the limit in force when it was updated
    a_integral_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ($signed(state_reg.integral) <= $signed({1'b0, $past(int_limit_reg)}))
                 && ($signed(state_reg.integral) >= -$signed({1'b0, $past(int_limit_reg)})))
        else $error("stored integral outside limit");

    // Only one direction pair of a result carries drive
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((out_reg.left_rev_duty == '0) && (out_reg.right_rev_duty == '0))
                     || ((out_reg.left_fwd_duty == '0) && (out_reg.right_fwd_duty == '0)))
        else $error("both direction pairs driven");

    // A held item stays in the in stage until the result register frees up
    a_in_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("stalled item lost from input stage");

    // Controller state moves only with an item
    a_state_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("controller state changed without an item");

endmodule

`default_nettype wire

[verif/tb_line_follow_pid_drive_core.sv]
// Self-checking testbench for line_follow_pid_drive_core: a directed table, then randomized
// sensor traffic under several gain sets, checked against table duties or an in-bench PID/drive predictor.
// Depends on lfpd_pkg and the core RTL.
`default_nettype none

module tb_line_follow_pid_drive_core;
    import lfpd_pkg::*;

    localparam int  HALF_PERIOD    = 10;
    localparam int  WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any port
    localparam int  HOLD_CYCLES    = 80;    // long receiver hold-off, fills both stages
    localparam int  ITEMS_PER_SET  = 150;
    localparam int  GAIN_SETS      = 7;
    localparam int  LATENCY        = 2;
    localparam int  NORMAL_STALL   = 24;    // percent of cycles each side idles
    localparam logic FWD = 1'b1;
    localparam logic REV = 1'b0;
    localparam logic [ADDR_W-1:0] NO_REG_ADDR = ADDR_W'(28);  // index 7: not mapped

    // One row of the directed table; want is used only when typed is set.
    typedef struct packed {
        item_t it;
        logic  typed;
        duty_t want;
    } row_t;

    localparam int DIRECTED_ROWS = 16;
    // Rows run from reset with the default gains; the state carries across rows.
    localparam row_t DIRECTED[DIRECTED_ROWS] = '{
        // speed zero: every duty zero
        '{'{12'd0,    12'd0,    12'd0,    FWD}, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0}},
        // balanced line, zero state: both sides run at top speed
        '{'{12'd2048, 12'd2048, 12'd4095, FWD}, 1'b1, '{12'd4095, 12'd0, 12'd4095, 12'd0}},
        // full error: P+I+D gains sum to exactly one, left drive hits zero, right clamps
        '{'{12'd4095, 12'd0,    12'd4095, FWD}, 1'b1, '{12'd0, 12'd0, 12'd4095, 12'd0}},
        // full swing the other way: deepest derivative
        '{'{12'd0,    12'd4095, 12'd4095, FWD}, 1'b0, '0},
        '{'{12'd0,    12'd4095, 12'd4095, REV}, 1'b0, '0},
        '{'{12'd4095, 12'd0,    12'd4095, REV}, 1'b0, '0},
        // one-count errors: fractional drives
        '{'{12'd1,    12'd0,    12'd100,  FWD}, 1'b0, '0},
        '{'{12'd0,    12'd1,    12'd100,  REV}, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 12'd4095, REV}, 1'b0, '0},
        '{'{12'd0,    12'd0,    12'd4095, REV}, 1'b0, '0},
        '{'{12'd2730, 12'd1365, 12'd2730, FWD}, 1'b0, '0},
        '{'{12'd1365, 12'd2730, 12'd1365, REV}, 1'b0, '0},
        '{'{12'd3000, 12'd2990, 12'd3000, FWD}, 1'b0, '0},
        '{'{12'd100,  12'd0,    12'd1,    FWD}, 1'b0, '0},
        '{'{12'd0,    12'd0,    12'd1,    FWD}, 1'b0, '0},
        // speed zero in reverse: nothing can drive
        '{'{12'd4095, 12'd0,    12'd0,    REV}, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0}}
    };

    // DUT ports, all inputs known from time zero
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [DATA_W-1:0]      pwdata   = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // Predictor copy of the register file and the controller state
    gain_set_t               fwd_gains;
    gain_set_t               rev_gains;
    logic [LIM_W-1:0]        int_limit;
    logic signed [ERR_W-1:0] integ_q;
    logic signed [ERR_W-1:0] last_err_q;

    duty_t duty_q[$];        // predicted duties, oldest first
    int    errors       = 0;
    int    quiet_cycles = 0;
    int    stall_pct    = NORMAL_STALL;
    bit    hold_req     = 1'b0;
    int    hold_left    = 0;

    line_follow_pid_drive_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------

    // Drop the fraction bits of a positive drive, clamp to 0..speed.
    function automatic logic [DUTY_W-1:0] drive_duty(input longint drv,
                                                     input logic [SPEED_W-1:0] speed);
        longint whole;
        if (drv <= 0)
            return '0;
        whole = drv >>> GAIN_FRAC_BITS;
        return (whole > speed) ? speed : whole[DUTY_W-1:0];
    endfunction

    // One control step: returns the duties and advances integral and last error.
    function automatic duty_t pid_step(input item_t it);
        gain_set_t g;
        longint    kp, ki, kd, lim, speed;
        longint    err, acc, deriv, sum, base;
        logic [DUTY_W-1:0] lduty, rduty;
        duty_t     d;
        g     = it.go_forward ? fwd_gains : rev_gains;
        kp    = g.prop;
        ki    = g.integ;
        kd    = g.deriv;
        lim   = int_limit;
        speed = it.top_speed;
        err   = longint'(it.left_sample) - longint'(it.right_sample);
        acc   = integ_q + err;           // unsaturated sum feeds the I term
        deriv = err - last_err_q;
        last_err_q = ERR_W'(err);
        sum   = kp * err + ki * acc + kd * deriv;
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;
        integ_q = ERR_W'(acc);
        base  = speed << GAIN_FRAC_BITS;
        lduty = drive_duty(base - sum, it.top_speed);
        rduty = drive_duty(base + sum, it.top_speed);
        d = '0;
        if (it.go_forward) begin
            d.left_fwd_duty  = lduty;
            d.right_fwd_duty = rduty;
        end else begin
            d.left_rev_duty  = lduty;
            d.right_rev_duty = rduty;
        end
        return d;
    endfunction

    // ---------------------------------------------------------------------------------
    // Configuration port. Called at a falling edge; returns at a falling edge with psel
    // still high so back-to-back accesses never lower and raise it in one step.
    // ---------------------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        logic [GAIN_W-1:0] v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) begin
            v = wdata[GAIN_W-1:0];      // upper bits of the bus are dropped
            case (reg_idx_t'(addr[4:2]))
                REG_FWD_PROP:  fwd_gains.prop  = v;
                REG_FWD_INT:   fwd_gains.integ = v;
                REG_FWD_DERIV: fwd_gains.deriv = v;
                REG_REV_PROP:  rev_gains.prop  = v;
                REG_REV_INT:   rev_gains.integ = v;
                REG_REV_DERIV: rev_gains.deriv = v;
                REG_INT_LIMIT: int_limit       = v;
                default: ;                  // unmapped index: ignored
            endcase
        end
        @(negedge aclk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Write all seven registers (random junk above bit 11), optionally poke the unmapped
    // slot, then read every register back.
    task automatic program_gains(input gain_set_t f, input gain_set_t r,
                                 input logic [LIM_W-1:0] lim, input bit poke_unmapped);
        logic [GAIN_W-1:0] vals[7];
        logic [DATA_W-1:0] rd, want;
        vals = '{f.prop, f.integ, f.deriv, r.prop, r.integ, r.deriv, lim};
        for (int i = 0; i < 7; i++)
            apb_access(1'b1, ADDR_W'(4 * i), {$urandom()} << GAIN_W | vals[i], rd);
        if (poke_unmapped)
            apb_access(1'b1, NO_REG_ADDR, $urandom(), rd);
        for (int i = 0; i < 7; i++) begin
            apb_access(1'b0, ADDR_W'(4 * i), '0, rd);
            case (reg_idx_t'(i))
                REG_FWD_PROP:  want = fwd_gains.prop;
                REG_FWD_INT:   want = fwd_gains.integ;
                REG_FWD_DERIV: want = fwd_gains.deriv;
                REG_REV_PROP:  want = rev_gains.prop;
                REG_REV_INT:   want = rev_gains.integ;
                REG_REV_DERIV: want = rev_gains.deriv;
                default:       want = int_limit;
            endcase
            if (rd !== want)
                report_mismatch($sformatf("readback of register %0d", i), rd, want);
        end
        apb_release();
    endtask

    // ---------------------------------------------------------------------------------
    // Input side. Called at a falling edge, returns at the falling edge after the transfer
    // with tvalid still high; the caller lowers it when the stream pauses.
    // ---------------------------------------------------------------------------------
    task automatic send_item(input item_t it, input logic typed, input duty_t want);
        duty_t predicted;
        while ($urandom_range(99) < stall_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({it.top_speed, it.right_sample, it.left_sample});
        s_tuser  <= it.go_forward;
        do @(posedge aclk); while (!s_tready);
        // transfer taken: the predictor always steps so the state stays in line
        predicted = pid_step(it);
        duty_q.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (duty_q.size() != 0)
            @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    function automatic logic [11:0] rand_value12();
        case ($urandom_range(9))
            0:       return 12'd0;
            1:       return 12'd4095;
            2, 3, 4: return 12'($urandom_range(400));   // plausible tuning range
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic gain_set_t rand_gains();
        gain_set_t g;
        g.prop  = rand_value12();
        g.integ = rand_value12();
        g.deriv = rand_value12();
        return g;
    endfunction

    // Half near-balanced sensor pairs (a robot tracking the line), the rest anywhere.
    function automatic item_t rand_item();
        item_t it;
        int    centre, delta;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                centre = $urandom_range(4095);
                delta  = $urandom_range(128) - 64;
                it.left_sample  = 12'((centre + delta < 0) ? 0 :
                                      (centre + delta > 4095) ? 4095 : centre + delta);
                it.right_sample = 12'(centre);
            end
            9: begin
                it.left_sample  = $urandom_range(1) ? 12'd4095 : 12'd0;
                it.right_sample = $urandom_range(1) ? 12'd4095 : 12'd0;
            end
            default: begin
                it.left_sample  = 12'($urandom());
                it.right_sample = 12'($urandom());
            end
        endcase
        it.top_speed  = $urandom_range(7) == 0 ? 12'($urandom_range(15)) : 12'($urandom());
        it.go_forward = ($urandom_range(9) < 7) ? FWD : REV;
        return it;
    endfunction

    // ---------------------------------------------------------------------------------
    // Result side: random stalls plus one long hold-off counted here
    // ---------------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction, field by field
    always @(posedge aclk) begin
        duty_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_q.size() == 0) begin
                report_mismatch("result transfer with nothing expected", m_tdata, 0);
            end else begin
                want = duty_q.pop_front();
                if (m_tdata[11:0] !== want.left_fwd_duty)
                    report_mismatch("left_fwd_duty", m_tdata[11:0], want.left_fwd_duty);
                if (m_tdata[23:12] !== want.left_rev_duty)
                    report_mismatch("left_rev_duty", m_tdata[23:12], want.left_rev_duty);
                if (m_tdata[35:24] !== want.right_fwd_duty)
                    report_mismatch("right_fwd_duty", m_tdata[35:24], want.right_fwd_duty);
                if (m_tdata[47:36] !== want.right_rev_duty)
                    report_mismatch("right_rev_duty", m_tdata[47:36], want.right_rev_duty);
            end
        end
    end

    // Watchdog: any transfer on any port counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin
        gain_set_t f, r;
        logic [LIM_W-1:0] lim;

        fwd_gains  = '{FWD_PROP_RST, FWD_INT_RST, FWD_DERIV_RST};
        rev_gains  = '{REV_PROP_RST, REV_INT_RST, REV_DERIV_RST};
        int_limit  = INT_LIMIT_RST;
        integ_q    = '0;
        last_err_q = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values on the register file, then the directed table
        program_gains(fwd_gains, rev_gains, int_limit, 1'b0);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
        drain();

        // Gain sets: all-max with zero limit (integral pinned at zero), all-zero with
        // widest limit and no idling, reset gains with the long hold-off, then random.
        for (int set_no = 0; set_no < GAIN_SETS; set_no++) begin
            case (set_no)
                0: begin
                    f = '1; r = '1; lim = '0;
                end
                1: begin
                    f = '0; r = '0; lim = '1;
                end
                2: begin
                    f   = '{FWD_PROP_RST, FWD_INT_RST, FWD_DERIV_RST};
                    r   = '{REV_PROP_RST, REV_INT_RST, REV_DERIV_RST};
                    lim = INT_LIMIT_RST;
                end
                default: begin
                    f = rand_gains(); r = rand_gains(); lim = rand_value12();
                end
            endcase
            stall_pct = (set_no == 1) ? 0 : NORMAL_STALL;
            program_gains(f, r, lim, set_no == 0);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (set_no == 2 && n == 40)
                    hold_req = 1'b1;   // receiver stops, sender keeps offering
                send_item(rand_item(), 1'b0, '0);
            end
            drain();
        end

        repeat (LATENCY + 4) @(posedge aclk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[line_follow_pid_drive_core.f]
rtl/lfpd_pkg.sv
rtl/lfpd_law.sv
rtl/line_follow_pid_drive_core.sv
verif/tb_line_follow_pid_drive_core.sv
